/* rtl/wcl_pkg.sv */
// ----------------------------------------------------------------------------
// wcl_pkg
// Shared constants of the weld column locator: register indexes, fixed field
// widths and register reset values.
// ----------------------------------------------------------------------------
package wcl_pkg;

  // fixed field widths
  localparam int THR_W    = 17;
  localparam int LIMIT_W  = 11;
  localparam int MINL_W   = 10;
  localparam int SENS_W   = 8;
  localparam int COLS_W   = 10;
  localparam int MASK_W   = 4;
  localparam int POS_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WELD_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSORS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MASK      = 3'd6;

  // register reset values
  localparam logic [SENS_W-1:0] SENS_RST = 8'd128;
  localparam logic [COLS_W-1:0] COLS_RST = 10'd512;
  localparam logic [MASK_W-1:0] MASK_RST = 4'd3;

endpackage

/* rtl/weld_column_locator.sv */
// ----------------------------------------------------------------------------
// weld_column_locator
// Loads two gradient images into a pixel pair store and, on the last pixel,
// scans column windows for the weld seam position.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, samples, last_pixel    | pixel pair words in
//  out     | out_valid/out_ready, out_weld_position    | seam column out
//  cfg     | cfg_we, cfg_index, cfg_wdata              | register writes
//
//  Load: one word per cycle while no scan runs and no result is pending.
//  Scan: starts when the last pixel is accepted and reads (columns - mask)
//  windows of mask * sensors words, one store read per cycle through the single
//  read port; a weld mode early stop ends it sooner, no read when no window fits.
//  Reset is synchronous; the stores need no clearing pass.
//  A pending result stalls input until it is taken.
// ----------------------------------------------------------------------------
module weld_column_locator
  import wcl_pkg::*;
#(
  parameter int MAX_SENSORS = 128,
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_MASK    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_primary_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_secondary_sample,
  input  logic in_last_pixel,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [POS_W-1:0] out_weld_position,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_SENSORS * MAX_COLUMNS;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(MAX_SENSORS + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int MW = $clog2(MAX_MASK + 1);
  localparam int PW = $clog2(MAX_COLUMNS + MAX_MASK + 1) + 1;

  logic signed [THR_W-1:0] thr_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [MINL_W-1:0]  minl_r;
  logic               wmode_r;
  logic [SENS_W-1:0]  sens_r;
  logic [COLS_W-1:0]  cols_r;
  logic [MASK_W-1:0]  mask_r;
  logic [SW-1:0] sens_sat;
  logic [CW-1:0] cols_sat;
  logic [MW-1:0] mask_sat;

  logic [AW-1:0] load_addr_r, load_addr_nxt;
  logic [AW:0]   load_inc;
  logic accept, start;
  logic out_valid_r;
  logic signed [PW-1:0] out_pos_r;

  logic rd_en, busy, done;
  logic [AW-1:0] rd_addr;
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic signed [PW-1:0] scan_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      limit_r <= '0;
      minl_r <= '0;
      wmode_r <= 1'b1;
      sens_r <= SENS_RST;
      cols_r <= COLS_RST;
      mask_r <= MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_wdata;
        REG_LIMIT:     limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_MIN_LEN:   minl_r <= cfg_wdata[MINL_W-1:0];
        REG_WELD_MODE: wmode_r <= cfg_wdata[0];
        REG_SENSORS:   sens_r <= cfg_wdata[SENS_W-1:0];
        REG_COLUMNS:   cols_r <= cfg_wdata[COLS_W-1:0];
        REG_MASK:      mask_r <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry clamped to the store size
  assign sens_sat = (32'(sens_r) > MAX_SENSORS) ? SW'(MAX_SENSORS) : SW'(sens_r);
  assign cols_sat = (32'(cols_r) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cols_r);
  assign mask_sat = (32'(mask_r) > MAX_MASK) ? MW'(MAX_MASK) : MW'(mask_r);

  // load address, wraps at the store end, back to zero after each image
  assign in_ready = !busy && !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign start    = accept && in_last_pixel;
  assign load_inc = {1'b0, load_addr_r} + (AW+1)'(1);

  always_comb begin
    load_addr_nxt = load_addr_r;
    if (accept) begin
      if (in_last_pixel || load_inc == (AW+1)'(DEPTH)) begin
        load_addr_nxt = '0;
      end else begin
        load_addr_nxt = load_inc[AW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      load_addr_r <= load_addr_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_pos_r <= scan_pos;
    end
  end

  assign out_valid = out_valid_r;
  assign out_weld_position = POS_W'(out_pos_r);

  wcl_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (2 * SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (load_addr_r),
    .wr_data ({in_secondary_sample, in_primary_sample}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wcl_scan #(
    .MAX_SENSORS (MAX_SENSORS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_MASK    (MAX_MASK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .thr       (thr_r),
    .limit     (limit_r),
    .min_len   (minl_r),
    .weld_mode (wmode_r),
    .sens      (sens_sat),
    .cols      (cols_sat),
    .mask      (mask_sat),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .done      (done),
    .pos       (scan_pos)
  );

`ifndef NO_ASSERTIONS
  // the last pixel always launches a scan
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("scan not started after last pixel");

  // no scan result while the previous one is still pending
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !out_valid_r)
    else $error("scan finished over a pending result");

  // pixels are never written during a scan
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept)
    else $error("pixel accepted during scan");
`endif

endmodule

/* rtl/wcl_store.sv */
// ----------------------------------------------------------------------------
// wcl_store
// Pixel pair memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wcl_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/wcl_scan.sv */
// ----------------------------------------------------------------------------
// wcl_scan
// Window scan sequencer: issues one store read a cycle, accumulates hot
// pixel counts and column peaks in the cycle after, keeps the best candidate.
// ----------------------------------------------------------------------------
module wcl_scan
  import wcl_pkg::*;
#(
  parameter int MAX_SENSORS = 128,
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_MASK    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [THR_W-1:0] thr,
  input  logic [LIMIT_W-1:0] limit,
  input  logic [MINL_W-1:0]  min_len,
  input  logic               weld_mode,
  input  logic [$clog2(MAX_SENSORS+1)-1:0] sens,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0] cols,
  input  logic [$clog2(MAX_MASK+1)-1:0]    mask,
  output logic rd_en,
  output logic [$clog2(MAX_SENSORS*MAX_COLUMNS)-1:0] rd_addr,
  input  logic [2*SAMPLE_BITS-1:0] rd_data,
  output logic busy,
  output logic done,
  output logic signed [$clog2(MAX_COLUMNS+MAX_MASK+1):0] pos
);

  localparam int DEPTH = MAX_SENSORS * MAX_COLUMNS;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(MAX_SENSORS + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int MW = $clog2(MAX_MASK + 1);
  localparam int NW = $clog2(MAX_SENSORS * MAX_MASK + 1);
  localparam int PW = $clog2(MAX_COLUMNS + MAX_MASK + 1) + 1;
  localparam int XW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic issue_r, issue_nxt;
  logic [AW-1:0] addr_r, addr_nxt, base_r, base_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic [MW-1:0] j_r, j_nxt;
  logic [CW-1:0] d_r, d_nxt, last_d_r, last_d_nxt;

  // process stage tags
  logic p_valid_r, p_valid_nxt, p_col_end_r, p_win_end_r;
  logic [CW-1:0] p_d_r;

  logic [NW-1:0] cnt_r, cnt_nxt, best_cnt_r, best_cnt_nxt;
  logic [SW-1:0] col_r, col_nxt, peak_r, peak_nxt;
  logic [MW-1:0] steps_r, steps_nxt;
  logic signed [PW-1:0] best_r, best_nxt;

  logic col_end, win_end;
  logic [AW:0] addr_inc, base_sum;
  logic [AW-1:0] addr_step;
  logic signed [XW-1:0] a_x, b_x, t_x;
  logic hot, hot2, new_peak, qualify, brk;
  logic [NW-1:0] cnt_tot;
  logic [SW-1:0] col_tot;
  logic [MW-1:0] steps_tot;
  logic signed [PW-1:0] cand;
  logic signed [31:0] minl_s, gap;

  // issue side
  assign col_end  = (k_r == sens - SW'(1));
  assign win_end  = col_end && (j_r == mask - MW'(1));
  assign addr_inc = {1'b0, addr_r} + (AW+1)'(1);
  assign addr_step = (addr_inc == (AW+1)'(DEPTH)) ? '0 : addr_inc[AW-1:0];
  assign base_sum = {1'b0, base_r} + (AW+1)'(sens);
  assign rd_en    = issue_r;
  assign rd_addr  = addr_r;

  // process side
  assign a_x = XW'($signed(rd_data[SAMPLE_BITS-1:0]));
  assign b_x = XW'($signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]));
  assign t_x = XW'(thr);
  assign hot  = (a_x > t_x) || ((b_x > t_x) && (a_x < t_x));
  assign hot2 = (a_x > t_x) || (b_x > t_x);
  assign cnt_tot  = cnt_r + NW'(hot);
  assign col_tot  = col_r + SW'(hot2);
  assign new_peak = col_tot > peak_r;
  assign steps_tot = steps_r + MW'(p_col_end_r && new_peak);
  assign cand   = PW'(p_d_r) + PW'(steps_tot);
  assign minl_s = signed'(32'(min_len));
  assign gap    = signed'(32'(p_d_r)) - 32'(best_r);
  assign qualify = (32'(cnt_tot) > 32'(limit)) && (cnt_tot > best_cnt_r) &&
                   (32'(cand) > minl_s);
  assign brk = qualify && weld_mode && (gap > minl_s) && (best_cnt_r != '0) &&
               (32'(best_r) > minl_s);

  always_comb begin
    state_nxt = state_r;
    issue_nxt = issue_r;
    addr_nxt = addr_r;
    base_nxt = base_r;
    k_nxt = k_r;
    j_nxt = j_r;
    d_nxt = d_r;
    last_d_nxt = last_d_r;
    p_valid_nxt = issue_r;
    cnt_nxt = cnt_r;
    col_nxt = col_r;
    peak_nxt = peak_r;
    steps_nxt = steps_r;
    best_cnt_nxt = best_cnt_r;
    best_nxt = best_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          addr_nxt = '0;
          base_nxt = '0;
          k_nxt = '0;
          j_nxt = '0;
          d_nxt = '0;
          last_d_nxt = cols - CW'(mask) - CW'(1);
          cnt_nxt = '0;
          col_nxt = '0;
          peak_nxt = '0;
          steps_nxt = '0;
          best_cnt_nxt = '0;
          best_nxt = '1;
          if (sens == '0 || mask == '0 || 32'(mask) >= 32'(cols)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_RUN;
            issue_nxt = 1'b1;
          end
        end
      end
      ST_RUN: begin
        // address walk over the window
        if (issue_r) begin
          if (!col_end) begin
            k_nxt = k_r + SW'(1);
            addr_nxt = addr_step;
          end else if (!win_end) begin
            k_nxt = '0;
            j_nxt = j_r + MW'(1);
            addr_nxt = addr_step;
          end else begin
            k_nxt = '0;
            j_nxt = '0;
            base_nxt = (base_sum >= (AW+1)'(DEPTH)) ?
                       AW'(base_sum - (AW+1)'(DEPTH)) : base_sum[AW-1:0];
            addr_nxt = base_nxt;
            d_nxt = d_r + CW'(1);
            if (d_r == last_d_r) begin
              issue_nxt = 1'b0;
            end
          end
        end
        // accumulate and evaluate
        if (p_valid_r) begin
          cnt_nxt = cnt_tot;
          col_nxt = col_tot;
          if (p_col_end_r) begin
            col_nxt = '0;
            steps_nxt = steps_tot;
            if (new_peak) begin
              peak_nxt = col_tot;
            end
          end
          if (p_win_end_r) begin
            cnt_nxt = '0;
            peak_nxt = '0;
            steps_nxt = '0;
            if (brk) begin
              state_nxt = ST_FIN;
              issue_nxt = 1'b0;
              p_valid_nxt = 1'b0;
            end else begin
              if (qualify) begin
                best_cnt_nxt = cnt_tot;
                best_nxt = cand;
              end
              if (p_d_r == last_d_r) begin
                state_nxt = ST_FIN;
              end
            end
          end
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
        p_valid_nxt = 1'b0;
      end
      default: begin
        state_nxt = ST_IDLE;
        issue_nxt = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issue_r <= 1'b0;
      p_valid_r <= 1'b0;
      best_cnt_r <= '0;
      best_r <= '1;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      p_valid_r <= p_valid_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_r <= best_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    base_r <= base_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    d_r <= d_nxt;
    last_d_r <= last_d_nxt;
    cnt_r <= cnt_nxt;
    col_r <= col_nxt;
    peak_r <= peak_nxt;
    steps_r <= steps_nxt;
    p_col_end_r <= col_end;
    p_win_end_r <= win_end;
    p_d_r <= d_r;
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_FIN);
  assign pos  = best_r;

endmodule
